// ----- rtl/ttri_pkg.sv -----
`default_nettype none
package ttri_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int NUM_SLOTS      = 6;
	localparam int SLOT_W         = 3;

	// Sign of an exact determinant or turn value.
	typedef struct packed {
		logic neg;
		logic zero;
	} sgn_t;

	typedef logic [SLOT_W-1:0] slot_t;

endpackage
`default_nettype wire

// ----- rtl/ttri_front.sv -----
`default_nettype none
module ttri_front #(
	parameter int COORD_BITS = ttri_pkg::COORD_BITS_DEF
) (
	input  wire logic                                              clk,
	input  wire logic                                              arst_n,
	input  wire logic                                              s_tvalid,
	output logic                                                   s_tready,
	// coord_x, coord_y, coord_z
	input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]                 s_tdata,
	// vertex_slot, evaluate
	input  wire logic [ttri_pkg::SLOT_W:0]                         s_tuser,
	output logic                                                   push,
	output logic [ttri_pkg::NUM_SLOTS*3*COORD_BITS-1:0]            snap,
	input  wire logic                                              full
);
	import ttri_pkg::*;

	localparam int VW = 3*COORD_BITS;

	logic [VW-1:0] vs_q [NUM_SLOTS];
	logic          acc;
	logic          wr;
	slot_t         slot;

	assign s_tready = !full;
	assign acc      = s_tvalid && s_tready;
	assign slot     = s_tuser[SLOT_W-1:0];
	assign wr       = acc && (slot < slot_t'(NUM_SLOTS));
	// An evaluate beat hands the store, including its own vertex, to the back end.
	assign push     = acc && s_tuser[SLOT_W];

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (wr && slot == slot_t'(i))
				snap[i*VW +: VW] = s_tdata[VW-1:0];
			else
				snap[i*VW +: VW] = vs_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++)
				vs_q[i] <= '0;
		end else if (wr) begin
			vs_q[slot] <= s_tdata[VW-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ttri_fifo.sv -----
`default_nettype none
module ttri_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  valid
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full)
				wr_q <= !wr_q;
			if (pop && valid)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && valid);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ttri_orient.sv -----
`default_nettype none
module ttri_orient #(
	parameter int COORD_BITS = ttri_pkg::COORD_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [3*COORD_BITS-1:0] a_pt,
	input  wire logic [3*COORD_BITS-1:0] b_pt,
	input  wire logic [3*COORD_BITS-1:0] c_pt,
	input  wire logic [3*COORD_BITS-1:0] d_pt,
	output logic                         done,
	output ttri_pkg::sgn_t               sgn
);
	import ttri_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int RW = C + 1;
	localparam int MW = 2*RW + 1;
	localparam int TW = MW + RW;
	localparam int SW = TW + 2;

	logic signed [RW-1:0]   r_s1  [3][3];
	logic signed [MW-1:0]   m_s2  [3];
	logic signed [RW-1:0]   r0_s2 [3];
	logic signed [TW-1:0]   t_s3  [3];
	sgn_t                   sgn_s4;
	logic [3:0]             vld_q;

	logic signed [RW-1:0]   r_d [3][3];
	logic signed [2*RW-1:0] pp  [6];
	logic signed [MW-1:0]   m_d [3];
	logic signed [TW-1:0]   t_d [3];
	logic signed [SW-1:0]   sum_d;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			r_d[0][j] = RW'($signed(a_pt[j*C +: C])) - RW'($signed(d_pt[j*C +: C]));
			r_d[1][j] = RW'($signed(b_pt[j*C +: C])) - RW'($signed(d_pt[j*C +: C]));
			r_d[2][j] = RW'($signed(c_pt[j*C +: C])) - RW'($signed(d_pt[j*C +: C]));
		end
		pp[0] = r_s1[1][1] * r_s1[2][2];
		pp[1] = r_s1[1][2] * r_s1[2][1];
		pp[2] = r_s1[1][2] * r_s1[2][0];
		pp[3] = r_s1[1][0] * r_s1[2][2];
		pp[4] = r_s1[1][0] * r_s1[2][1];
		pp[5] = r_s1[1][1] * r_s1[2][0];
		for (int k = 0; k < 3; k++)
			m_d[k] = MW'(pp[2*k]) - MW'(pp[2*k+1]);
		for (int k = 0; k < 3; k++)
			t_d[k] = m_s2[k] * r0_s2[k];
		sum_d = SW'(t_s3[0]) + SW'(t_s3[1]) + SW'(t_s3[2]);
	end

	always_ff @(posedge clk) begin
		r_s1 <= r_d;
		m_s2 <= m_d;
		for (int j = 0; j < 3; j++)
			r0_s2[j] <= r_s1[0][j];
		t_s3 <= t_d;
		sgn_s4.neg  <= sum_d[SW-1];
		sgn_s4.zero <= (sum_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[2:0], start};
	end

	assign done = vld_q[3];
	assign sgn  = sgn_s4;

endmodule
`default_nettype wire

// ----- rtl/ttri_inside.sv -----
`default_nettype none
module ttri_inside #(
	parameter int COORD_BITS = ttri_pkg::COORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [3*COORD_BITS-1:0]     v0,
	input  wire logic [3*COORD_BITS-1:0]     v1,
	input  wire logic [3*COORD_BITS-1:0]     v2,
	input  wire logic [3*(COORD_BITS+2)-1:0] p,
	input  wire logic                        k3,
	output logic                             done,
	output logic                             in_tri
);
	localparam int C   = COORD_BITS;
	localparam int PTW = C + 2;
	localparam int EW  = C + 3;
	localparam int QW  = 2*EW;
	localparam int DW  = QW + 2;
	localparam int H   = DW/2;
	localparam int LW  = DW + H + 1;
	localparam int UW  = DW - H + DW;
	localparam int XW  = 2*DW;
	localparam int PW  = XW + 4;

	logic signed [EW-1:0] e0_s1 [3];
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [QW-1:0] q_s2  [5][3];
	logic signed [DW-1:0] d_s3  [5];
	logic signed [LW-1:0] lo_s4 [6];
	logic signed [UW-1:0] hi_s4 [6];
	logic signed [XW-1:0] x_s5  [6];
	logic signed [PW-1:0] den_s6, nu_s6, nv_s6;
	logic signed [PW-1:0] lim_s7, nu_s7, nv_s7;
	logic                 dz_s7;
	logic                 res_s8;
	logic [6:1]           k3_q;
	logic [7:0]           vld_q;

	logic signed [EW-1:0] e0_d [3];
	logic signed [EW-1:0] e1_d [3];
	logic signed [EW-1:0] e2_d [3];
	logic signed [EW-1:0] w0, w1, w2;
	logic signed [QW-1:0] q_d  [5][3];
	logic signed [DW-1:0] d_d  [5];
	logic signed [DW-1:0] opa  [6];
	logic signed [DW-1:0] opb  [6];
	logic signed [LW-1:0] lo_d [6];
	logic signed [UW-1:0] hi_d [6];
	logic signed [XW-1:0] x_d  [6];
	logic signed [PW-1:0] den_n, nu_n, nv_n, lim_n;
	logic                 ok_d;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			w0 = EW'($signed(v0[j*C +: C]));
			w1 = EW'($signed(v1[j*C +: C]));
			w2 = EW'($signed(v2[j*C +: C]));
			e0_d[j] = w2 - w0;
			e1_d[j] = w1 - w0;
			// The centroid arrives scaled by three, so the base vertex is scaled to match.
			e2_d[j] = EW'($signed(p[j*PTW +: PTW])) - (k3 ? (w0 + (w0 <<< 1)) : w0);
		end
		for (int j = 0; j < 3; j++) begin
			q_d[0][j] = e0_s1[j] * e0_s1[j];
			q_d[1][j] = e0_s1[j] * e1_s1[j];
			q_d[2][j] = e0_s1[j] * e2_s1[j];
			q_d[3][j] = e1_s1[j] * e1_s1[j];
			q_d[4][j] = e1_s1[j] * e2_s1[j];
		end
		for (int k = 0; k < 5; k++)
			d_d[k] = DW'(q_s2[k][0]) + DW'(q_s2[k][1]) + DW'(q_s2[k][2]);
		// Operand order: d00 d11, d01 d01, d11 d02, d01 d12, d00 d12, d01 d02.
		opa[0] = d_s3[0]; opb[0] = d_s3[3];
		opa[1] = d_s3[1]; opb[1] = d_s3[1];
		opa[2] = d_s3[3]; opb[2] = d_s3[2];
		opa[3] = d_s3[1]; opb[3] = d_s3[4];
		opa[4] = d_s3[0]; opb[4] = d_s3[4];
		opa[5] = d_s3[1]; opb[5] = d_s3[2];
		for (int n = 0; n < 6; n++) begin
			lo_d[n] = opa[n] * $signed({1'b0, opb[n][H-1:0]});
			hi_d[n] = opa[n] * $signed(opb[n][DW-1:H]);
			x_d[n]  = (XW'(hi_s4[n]) <<< H) + XW'(lo_s4[n]);
		end
		den_n = den_s6[PW-1] ? -den_s6 : den_s6;
		nu_n  = den_s6[PW-1] ? -nu_s6 : nu_s6;
		nv_n  = den_s6[PW-1] ? -nv_s6 : nv_s6;
		lim_n = k3_q[6] ? (den_n + (den_n <<< 1)) : den_n;
		ok_d  = !dz_s7 && !nu_s7[PW-1] && !nv_s7[PW-1]
			&& !(lim_s7 - nu_s7 < 0) && !(lim_s7 - nv_s7 < 0)
			&& !(lim_s7 - nu_s7 - nv_s7 < 0);
	end

	always_ff @(posedge clk) begin
		e0_s1  <= e0_d;
		e1_s1  <= e1_d;
		e2_s1  <= e2_d;
		q_s2   <= q_d;
		d_s3   <= d_d;
		lo_s4  <= lo_d;
		hi_s4  <= hi_d;
		x_s5   <= x_d;
		den_s6 <= PW'(x_s5[0]) - PW'(x_s5[1]);
		nu_s6  <= PW'(x_s5[2]) - PW'(x_s5[3]);
		nv_s6  <= PW'(x_s5[4]) - PW'(x_s5[5]);
		dz_s7  <= (den_s6 == '0);
		lim_s7 <= lim_n;
		nu_s7  <= nu_n;
		nv_s7  <= nv_n;
		res_s8 <= ok_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			k3_q  <= '0;
		end else begin
			vld_q <= {vld_q[6:0], start};
			k3_q  <= {k3_q[5:1], k3};
		end
	end

	assign done   = vld_q[7];
	assign in_tri = res_s8;

endmodule
`default_nettype wire

// ----- rtl/ttri_back.sv -----
`default_nettype none
module ttri_back #(
	parameter int COORD_BITS = ttri_pkg::COORD_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   q_valid,
	input  wire logic [ttri_pkg::NUM_SLOTS*3*COORD_BITS-1:0] q_data,
	output logic                                        q_pop,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// intersects
	output logic [7:0]                                  m_tdata,
	// coplanar_case
	output logic [0:0]                                  m_tuser
);
	import ttri_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int VW  = 3*C;
	localparam int PTW = C + 2;
	localparam int RW  = C + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_S1   = 4'd1;
	localparam logic [3:0] ST_D1   = 4'd2;
	localparam logic [3:0] ST_S2   = 4'd3;
	localparam logic [3:0] ST_D2   = 4'd4;
	localparam logic [3:0] ST_F1   = 4'd5;
	localparam logic [3:0] ST_F2   = 4'd6;
	localparam logic [3:0] ST_COP  = 4'd7;
	localparam logic [3:0] ST_IN   = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	localparam logic [3:0] LAST_PAIR = 4'd8;

	logic [3:0]            state_q;
	logic [VW-1:0]         vs_q [NUM_SLOTS];
	sgn_t                  s1_q [3];
	sgn_t                  s2_q [3];
	logic [1:0]            idx_q;
	logic [3:0]            pc_q;
	slot_t                 t1_q [3];
	slot_t                 t2_q [3];
	logic                  ori_wait_q;
	logic                  in_wait_q;
	logic                  cen_first_q;
	logic                  in_base_q;
	logic signed [PTW-1:0] in_p_q [3];
	logic                  in_k3_q;
	logic                  hit_q;
	logic                  copl_q;
	logic                  m_tvalid_q;
	logic                  m_hit_q;
	logic                  m_copl_q;

	slot_t                 oa, ob, oc, od;
	logic                  ori_start, ori_done;
	sgn_t                  ori_sgn;
	logic                  in_start, in_done, in_res;
	logic [3*PTW-1:0]      in_p;
	logic signed [PTW-1:0] c1 [3];
	logic signed [PTW-1:0] c2 [3];
	slot_t                 t1n [3];
	slot_t                 t2n [3];
	slot_t                 tmp0;
	sgn_t                  s1p [3];
	logic                  mneg;
	slot_t                 sa, sb, sc, sd;
	sgn_t                  d1, d2, d3, d4;
	logic                  seg_hit;
	logic                  z1_0, z1_1, z1_2, z2_0, z2_1, z2_2;

	function automatic logic spos(input sgn_t s);
		return !s.neg && !s.zero;
	endfunction

	function automatic logic sgt(input sgn_t a, input sgn_t b);
		return (spos(a) && spos(b)) || (a.neg && b.neg);
	endfunction

	function automatic logic sge(input sgn_t a, input sgn_t b);
		return !((spos(a) && b.neg) || (a.neg && spos(b)));
	endfunction

	function automatic logic signed [C-1:0] crd(input logic [VW-1:0] v, input int j);
		return $signed(v[j*C +: C]);
	endfunction

	// Side of point q against the directed segment a-b, in the x-y plane.
	function automatic sgn_t turn(input logic [VW-1:0] a, input logic [VW-1:0] b,
		input logic [VW-1:0] q);
		logic signed [RW-1:0]   qx, qy, bx, by;
		logic signed [2*RW-1:0] m0, m1;
		logic signed [2*RW:0]   t;
		sgn_t                   r;
		qx = RW'(crd(q, 0)) - RW'(crd(a, 0));
		qy = RW'(crd(q, 1)) - RW'(crd(a, 1));
		bx = RW'(crd(b, 0)) - RW'(crd(a, 0));
		by = RW'(crd(b, 1)) - RW'(crd(a, 1));
		m0 = qx * by;
		m1 = bx * qy;
		t = (2*RW+1)'(m0) - (2*RW+1)'(m1);
		r.neg  = t[2*RW];
		r.zero = (t == '0);
		return r;
	endfunction

	function automatic logic inbox(input logic [VW-1:0] a, input logic [VW-1:0] b,
		input logic [VW-1:0] q);
		logic xin, yin;
		xin = (crd(q, 0) >= crd(a, 0) && crd(q, 0) <= crd(b, 0))
			|| (crd(q, 0) >= crd(b, 0) && crd(q, 0) <= crd(a, 0));
		yin = (crd(q, 1) >= crd(a, 1) && crd(q, 1) <= crd(b, 1))
			|| (crd(q, 1) >= crd(b, 1) && crd(q, 1) <= crd(a, 1));
		return xin && yin;
	endfunction

	function automatic logic opp(input sgn_t a, input sgn_t b);
		return (spos(a) && b.neg) || (a.neg && spos(b));
	endfunction

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			c1[j] = PTW'(crd(vs_q[0], j)) + PTW'(crd(vs_q[1], j)) + PTW'(crd(vs_q[2], j));
			c2[j] = PTW'(crd(vs_q[3], j)) + PTW'(crd(vs_q[4], j)) + PTW'(crd(vs_q[5], j));
			in_p[j*PTW +: PTW] = in_p_q[j];
		end
	end

	// Operand slots of the orientation unit for the step in progress.
	always_comb begin
		oa = slot_t'(0);
		ob = slot_t'(1);
		oc = slot_t'(2);
		od = slot_t'(3);
		case (state_q)
			ST_S1: od = slot_t'(3) + slot_t'(idx_q);
			ST_S2: begin
				oa = slot_t'(3);
				ob = slot_t'(4);
				oc = slot_t'(5);
				od = slot_t'(idx_q);
			end
			ST_F1: begin
				oa = t1_q[0];
				ob = t1_q[1];
				oc = t2_q[0];
				od = t2_q[1];
			end
			ST_F2: begin
				oa = t1_q[0];
				ob = t1_q[2];
				oc = t2_q[2];
				od = t2_q[0];
			end
			default: ;
		endcase
	end

	assign ori_start = (state_q == ST_S1 || state_q == ST_S2 || state_q == ST_F1
		|| state_q == ST_F2) && !ori_wait_q;
	assign in_start  = (state_q == ST_IN) && !in_wait_q;

	// Reorder both triangles so that the pivot vertices lead, as the final test expects.
	always_comb begin
		t1n[0] = slot_t'(0); t1n[1] = slot_t'(1); t1n[2] = slot_t'(2);
		t2n[0] = slot_t'(3); t2n[1] = slot_t'(4); t2n[2] = slot_t'(5);
		s1p  = s1_q;
		mneg = 1'b0;
		if (sge(s2_q[1], s2_q[2]) && !s2_q[0].zero) begin
			mneg = s2_q[0].neg;
		end else if (sge(s2_q[0], s2_q[2]) && !s2_q[1].zero) begin
			t1n[0] = slot_t'(1); t1n[1] = slot_t'(2); t1n[2] = slot_t'(0);
			mneg = s2_q[1].neg;
		end else if (sge(s2_q[0], s2_q[1]) && !s2_q[2].zero) begin
			t1n[0] = slot_t'(2); t1n[1] = slot_t'(0); t1n[2] = slot_t'(1);
			mneg = s2_q[2].neg;
		end
		if (mneg) begin
			t2n[1] = slot_t'(5);
			t2n[2] = slot_t'(4);
			s1p[1] = s1_q[2];
			s1p[2] = s1_q[1];
		end
		mneg = 1'b0;
		tmp0 = t2n[0];
		if (sge(s1p[1], s1p[2]) && !s1p[0].zero) begin
			mneg = s1p[0].neg;
		end else if (sge(s1p[0], s1p[2]) && !s1p[1].zero) begin
			t2n[0] = t2n[1];
			t2n[1] = t2n[2];
			t2n[2] = tmp0;
			mneg = s1p[1].neg;
		end else if (sge(s1p[0], s1p[1]) && !s1p[2].zero) begin
			t2n[0] = t2n[2];
			t2n[2] = t2n[1];
			t2n[1] = tmp0;
			mneg = s1p[2].neg;
		end
		if (mneg) begin
			tmp0   = t1n[1];
			t1n[1] = t1n[2];
			t1n[2] = tmp0;
		end
	end

	// Edge pair walked in the coplanar case: first-triangle edge a-b, second c-d.
	always_comb begin
		sa = slot_t'(0); sb = slot_t'(1); sc = slot_t'(3); sd = slot_t'(4);
		case (pc_q)
			4'd0: begin sa = slot_t'(0); sb = slot_t'(1); sc = slot_t'(3); sd = slot_t'(4); end
			4'd1: begin sa = slot_t'(0); sb = slot_t'(1); sc = slot_t'(4); sd = slot_t'(5); end
			4'd2: begin sa = slot_t'(0); sb = slot_t'(1); sc = slot_t'(3); sd = slot_t'(5); end
			4'd3: begin sa = slot_t'(1); sb = slot_t'(2); sc = slot_t'(3); sd = slot_t'(4); end
			4'd4: begin sa = slot_t'(1); sb = slot_t'(2); sc = slot_t'(4); sd = slot_t'(5); end
			4'd5: begin sa = slot_t'(1); sb = slot_t'(2); sc = slot_t'(3); sd = slot_t'(5); end
			4'd6: begin sa = slot_t'(0); sb = slot_t'(2); sc = slot_t'(3); sd = slot_t'(4); end
			4'd7: begin sa = slot_t'(0); sb = slot_t'(2); sc = slot_t'(4); sd = slot_t'(5); end
			4'd8: begin sa = slot_t'(0); sb = slot_t'(2); sc = slot_t'(3); sd = slot_t'(5); end
			default: ;
		endcase
		d1 = turn(vs_q[sc], vs_q[sd], vs_q[sa]);
		d2 = turn(vs_q[sc], vs_q[sd], vs_q[sb]);
		d3 = turn(vs_q[sa], vs_q[sb], vs_q[sc]);
		d4 = turn(vs_q[sa], vs_q[sb], vs_q[sd]);
		seg_hit = (opp(d1, d2) && opp(d3, d4))
			|| (d1.zero && inbox(vs_q[sc], vs_q[sd], vs_q[sa]))
			|| (d2.zero && inbox(vs_q[sc], vs_q[sd], vs_q[sb]))
			|| (d3.zero && inbox(vs_q[sa], vs_q[sb], vs_q[sc]))
			|| (d4.zero && inbox(vs_q[sa], vs_q[sb], vs_q[sd]));
	end

	// A lone in-plane vertex with the other two on one side.
	assign z1_0 = s1_q[0].zero && sgt(s1_q[1], s1_q[2]);
	assign z1_1 = s1_q[1].zero && sgt(s1_q[0], s1_q[2]);
	assign z1_2 = s1_q[2].zero && sgt(s1_q[0], s1_q[1]);
	assign z2_0 = s2_q[0].zero && sgt(s2_q[1], s2_q[2]);
	assign z2_1 = s2_q[1].zero && sgt(s2_q[0], s2_q[2]);
	assign z2_2 = s2_q[2].zero && sgt(s2_q[0], s2_q[1]);

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			pc_q        <= '0;
			ori_wait_q  <= 1'b0;
			in_wait_q   <= 1'b0;
			cen_first_q <= 1'b0;
			in_base_q   <= 1'b0;
			in_k3_q     <= 1'b0;
			hit_q       <= 1'b0;
			copl_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_hit_q     <= 1'b0;
			m_copl_q    <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++)
				vs_q[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				s1_q[i]   <= '0;
				s2_q[i]   <= '0;
				t1_q[i]   <= '0;
				t2_q[i]   <= '0;
				in_p_q[i] <= '0;
			end
		end else begin
			// The finishing step reloads the output register itself.
			if (m_tvalid_q && m_tready && state_q != ST_DONE)
				m_tvalid_q <= 1'b0;
			if (ori_start)
				ori_wait_q <= 1'b1;
			else if (ori_done)
				ori_wait_q <= 1'b0;
			if (in_start)
				in_wait_q <= 1'b1;
			else if (in_done)
				in_wait_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						for (int i = 0; i < NUM_SLOTS; i++)
							vs_q[i] <= q_data[i*VW +: VW];
						idx_q   <= '0;
						copl_q  <= 1'b0;
						state_q <= ST_S1;
					end
				end
				ST_S1: begin
					if (ori_wait_q && ori_done) begin
						s1_q[idx_q] <= ori_sgn;
						idx_q       <= idx_q + 2'd1;
						if (idx_q == 2'd2)
							state_q <= ST_D1;
					end
				end
				ST_D1: begin
					cen_first_q <= 1'b0;
					in_k3_q     <= 1'b0;
					in_base_q   <= 1'b0;
					for (int j = 0; j < 3; j++)
						in_p_q[j] <= PTW'(crd(z1_0 ? vs_q[3] : (z1_1 ? vs_q[4] : vs_q[5]), j));
					if ((spos(s1_q[0]) && spos(s1_q[1]) && spos(s1_q[2]))
						|| (s1_q[0].neg && s1_q[1].neg && s1_q[2].neg)) begin
						hit_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if (s1_q[0].zero && s1_q[1].zero && s1_q[2].zero) begin
						copl_q  <= 1'b1;
						pc_q    <= '0;
						state_q <= ST_COP;
					end else if (z1_0 || z1_1 || z1_2) begin
						state_q <= ST_IN;
					end else begin
						idx_q   <= '0;
						state_q <= ST_S2;
					end
				end
				ST_S2: begin
					if (ori_wait_q && ori_done) begin
						s2_q[idx_q] <= ori_sgn;
						idx_q       <= idx_q + 2'd1;
						if (idx_q == 2'd2)
							state_q <= ST_D2;
					end
				end
				ST_D2: begin
					cen_first_q <= 1'b0;
					in_k3_q     <= 1'b0;
					in_base_q   <= 1'b1;
					for (int j = 0; j < 3; j++)
						in_p_q[j] <= PTW'(crd(z2_0 ? vs_q[0] : (z2_1 ? vs_q[1] : vs_q[2]), j));
					t1_q <= t1n;
					t2_q <= t2n;
					if ((spos(s2_q[0]) && spos(s2_q[1]) && spos(s2_q[2]))
						|| (s2_q[0].neg && s2_q[1].neg && s2_q[2].neg)) begin
						hit_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if (z2_0 || z2_1 || z2_2) begin
						state_q <= ST_IN;
					end else begin
						state_q <= ST_F1;
					end
				end
				ST_F1: begin
					if (ori_wait_q && ori_done) begin
						if (spos(ori_sgn)) begin
							hit_q   <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_F2;
						end
					end
				end
				ST_F2: begin
					if (ori_wait_q && ori_done) begin
						hit_q   <= !spos(ori_sgn);
						state_q <= ST_DONE;
					end
				end
				ST_COP: begin
					if (seg_hit) begin
						hit_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (pc_q == LAST_PAIR) begin
						// Centroid of the first triangle against the second, then the reverse.
						in_base_q   <= 1'b1;
						in_k3_q     <= 1'b1;
						cen_first_q <= 1'b1;
						in_p_q      <= c1;
						state_q     <= ST_IN;
					end else begin
						pc_q <= pc_q + 4'd1;
					end
				end
				ST_IN: begin
					if (in_wait_q && in_done) begin
						if (in_res) begin
							hit_q   <= 1'b1;
							state_q <= ST_DONE;
						end else if (cen_first_q) begin
							cen_first_q <= 1'b0;
							in_base_q   <= 1'b0;
							in_p_q      <= c2;
						end else begin
							hit_q   <= 1'b0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_hit_q    <= hit_q;
						m_copl_q   <= copl_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	ttri_orient #(
		.COORD_BITS(COORD_BITS)
	) u_orient (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ori_start),
		.a_pt  (vs_q[oa]),
		.b_pt  (vs_q[ob]),
		.c_pt  (vs_q[oc]),
		.d_pt  (vs_q[od]),
		.done  (ori_done),
		.sgn   (ori_sgn)
	);

	ttri_inside #(
		.COORD_BITS(COORD_BITS)
	) u_inside (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_start),
		.v0    (in_base_q ? vs_q[3] : vs_q[0]),
		.v1    (in_base_q ? vs_q[4] : vs_q[1]),
		.v2    (in_base_q ? vs_q[5] : vs_q[2]),
		.p     (in_p),
		.k3    (in_k3_q),
		.done  (in_done),
		.in_tri(in_res)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, m_hit_q};
	assign m_tuser  = m_copl_q;

	a_ori_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		ori_done |-> ori_wait_q)
		else $error("orientation result without a pending request");

	a_in_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		in_done |-> in_wait_q)
		else $error("containment result without a pending request");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside the finishing step");

	a_copl_only_all_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COP) |-> (s1_q[0].zero && s1_q[1].zero && s1_q[2].zero))
		else $error("coplanar walk entered with a vertex off the plane");

endmodule
`default_nettype wire

// ----- rtl/triangle_triangle_intersect_3d_top.sv -----
// Triangle-triangle intersection test on exact integer coordinates.
// Input stream: each beat carries one vertex (x, y, z in tdata) and, in tuser,
// the slot it goes to (0-2 first triangle, 3-5 second; 6 and 7 store nothing)
// plus an evaluate flag. A beat with evaluate set stores its vertex and then
// tests the two stored triangles; it produces exactly one result beat.
// Output stream: tdata bit 0 is intersects, tuser bit 0 is coplanar_case.
// Vertex beats are taken one per cycle while the queue has room. An evaluate beat
// hands a copy of all six vertices to a two-entry queue, so loading the next pair of
// triangles goes on while the test runs. The test uses the orientation determinant
// unit (four stages, one request in flight), which it calls up to eight times, and
// the eight-stage containment unit in the coplanar and in-plane-vertex cases.
// Reset clears all six vertices to zero and empties the queue and the output.
// When the result receiver stalls, the finished result waits in the output
// register, the back end holds, and once the queue is full the input stalls.
`default_nettype none
module triangle_triangle_intersect_3d_top #(
	parameter int COORD_BITS = ttri_pkg::COORD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// coord_x, coord_y, coord_z
	input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// vertex_slot, evaluate
	input  wire logic [ttri_pkg::SLOT_W:0]         s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// intersects
	output logic [7:0]                             m_tdata,
	// coplanar_case
	output logic [0:0]                             m_tuser
);
	import ttri_pkg::*;

	localparam int SNAP_W = NUM_SLOTS*3*COORD_BITS;

	logic              push, full, pop, qv;
	logic [SNAP_W-1:0] snap, qd;

	ttri_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.push    (push),
		.snap    (snap),
		.full    (full)
	);

	ttri_fifo #(
		.WIDTH(SNAP_W)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (snap),
		.full  (full),
		.pop   (pop),
		.dout  (qd),
		.valid (qv)
	);

	ttri_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (qv),
		.q_data  (qd),
		.q_pop   (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
`default_nettype wire

// ----- test/tb_triangle_triangle_intersect_3d_top.sv -----
`default_nettype none
module tb_triangle_triangle_intersect_3d_top;

	localparam int CB = ttri_pkg::COORD_BITS_DEF;
	localparam int DW = ((3*CB+7)/8)*8;
	localparam int N_RANDOM = 800;
	localparam int CYCLE_LIMIT = 400000;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic signed [127:0] big_t;

	typedef struct packed {
		logic [2:0] slot;
		coord_t x;
		coord_t y;
		coord_t z;
		logic eval;
	} vtx_beat_t;

	typedef struct packed {
		logic hit;
		logic copl;
	} verdict_t;

	// Directed row: beat plus an optional typed-in verdict.
	typedef struct packed {
		vtx_beat_t beat;
		logic fixed;
		verdict_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DW-1:0] s_tdata = '0;
	logic [ttri_pkg::SLOT_W:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [0:0] m_tuser;

	triangle_triangle_intersect_3d_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// Predictor state: a copy of the six stored vertices.
	longint vtx [6][3];
	verdict_t pending_verdicts[$];
	int errors = 0;
	int cycles = 0;
	bit stim_done = 1'b0;

	function automatic int sgn_big(big_t v);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	function automatic int det_sign(int ia, int ib, int ic, int id);
		longint r [3][3];
		int idx [3];
		big_t s;
		idx[0] = ia; idx[1] = ib; idx[2] = ic;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				r[i][j] = vtx[idx[i]][j] - vtx[id][j];
		s = big_t'(r[0][0]) * big_t'(r[1][1] * r[2][2] - r[1][2] * r[2][1])
		  + big_t'(r[0][1]) * big_t'(r[1][2] * r[2][0] - r[1][0] * r[2][2])
		  + big_t'(r[0][2]) * big_t'(r[1][0] * r[2][1] - r[1][1] * r[2][0]);
		return sgn_big(s);
	endfunction

	function automatic int turn_xy(int a, int b, int c);
		longint v;
		v = (vtx[c][0] - vtx[a][0]) * (vtx[b][1] - vtx[a][1])
		  - (vtx[b][0] - vtx[a][0]) * (vtx[c][1] - vtx[a][1]);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	function automatic bit in_box(int a, int b, int c);
		longint xl, xh, yl, yh;
		xl = (vtx[a][0] < vtx[b][0]) ? vtx[a][0] : vtx[b][0];
		xh = (vtx[a][0] > vtx[b][0]) ? vtx[a][0] : vtx[b][0];
		yl = (vtx[a][1] < vtx[b][1]) ? vtx[a][1] : vtx[b][1];
		yh = (vtx[a][1] > vtx[b][1]) ? vtx[a][1] : vtx[b][1];
		return vtx[c][0] >= xl && vtx[c][0] <= xh && vtx[c][1] >= yl && vtx[c][1] <= yh;
	endfunction

	function automatic bit segs_meet(int a, int b, int c, int d);
		int d1, d2, d3, d4;
		d1 = turn_xy(c, d, a); d2 = turn_xy(c, d, b);
		d3 = turn_xy(a, b, c); d4 = turn_xy(a, b, d);
		if (d1 * d2 < 0 && d3 * d4 < 0) return 1'b1;
		if (d1 == 0 && in_box(c, d, a)) return 1'b1;
		if (d2 == 0 && in_box(c, d, b)) return 1'b1;
		if (d3 == 0 && in_box(a, b, c)) return 1'b1;
		if (d4 == 0 && in_box(a, b, d)) return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit edge_hits_tri(int t, int f1, int f2);
		return segs_meet(f1, f2, t, t + 1) || segs_meet(f1, f2, t + 1, t + 2)
		    || segs_meet(f1, f2, t, t + 2);
	endfunction

	// Point p, scaled by k, inside the triangle at base slot t (cross-multiplied).
	function automatic bit point_in_tri(int t, longint px, longint py, longint pz, int k);
		longint p [3];
		longint e0, e1, e2;
		longint d00, d01, d02, d11, d12;
		big_t den, nu, nv;
		p[0] = px; p[1] = py; p[2] = pz;
		d00 = 0; d01 = 0; d02 = 0; d11 = 0; d12 = 0;
		for (int i = 0; i < 3; i++) begin
			e0 = vtx[t+2][i] - vtx[t][i];
			e1 = vtx[t+1][i] - vtx[t][i];
			e2 = p[i] - k * vtx[t][i];
			d00 += e0 * e0; d01 += e0 * e1; d02 += e0 * e2;
			d11 += e1 * e1; d12 += e1 * e2;
		end
		den = big_t'(d00) * big_t'(d11) - big_t'(d01) * big_t'(d01);
		if (den == 0) return 1'b0;
		nu = big_t'(d11) * big_t'(d02) - big_t'(d01) * big_t'(d12);
		nv = big_t'(d00) * big_t'(d12) - big_t'(d01) * big_t'(d02);
		if (den < 0) begin
			den = -den; nu = -nu; nv = -nv;
		end
		den = den * k;
		if (nu < 0 || nu > den || nv < 0 || nv > den) return 1'b0;
		return nu + nv <= den;
	endfunction

	function automatic bit coplanar_hit();
		longint c1 [3], c2 [3];
		if (edge_hits_tri(3, 0, 1) || edge_hits_tri(3, 1, 2) || edge_hits_tri(3, 0, 2))
			return 1'b1;
		for (int i = 0; i < 3; i++) begin
			c1[i] = vtx[0][i] + vtx[1][i] + vtx[2][i];
			c2[i] = vtx[3][i] + vtx[4][i] + vtx[5][i];
		end
		return point_in_tri(3, c1[0], c1[1], c1[2], 3)
		    || point_in_tri(0, c2[0], c2[1], c2[2], 3);
	endfunction

	function automatic bit vtx_in_tri(int t, int v);
		return point_in_tri(t, vtx[v][0], vtx[v][1], vtx[v][2], 1);
	endfunction

	function automatic verdict_t triangles_meet();
		int s1 [3], s2 [3], t1 [3], t2 [3];
		int m, tmp;
		verdict_t r;
		r.copl = 1'b0;
		t1[0] = 0; t1[1] = 1; t1[2] = 2;
		t2[0] = 3; t2[1] = 4; t2[2] = 5;
		for (int i = 0; i < 3; i++) s1[i] = det_sign(0, 1, 2, 3 + i);
		r.hit = 1'b0;
		if (s1[0] > 0 && s1[1] > 0 && s1[2] > 0) return r;
		if (s1[0] < 0 && s1[1] < 0 && s1[2] < 0) return r;
		if (s1[0] == 0 && s1[1] == 0 && s1[2] == 0) begin
			r.copl = 1'b1;
			r.hit = coplanar_hit();
			return r;
		end
		if (s1[0] == 0 && s1[1] * s1[2] > 0) begin r.hit = vtx_in_tri(0, 3); return r; end
		if (s1[1] == 0 && s1[0] * s1[2] > 0) begin r.hit = vtx_in_tri(0, 4); return r; end
		if (s1[2] == 0 && s1[0] * s1[1] > 0) begin r.hit = vtx_in_tri(0, 5); return r; end
		for (int i = 0; i < 3; i++) s2[i] = det_sign(3, 4, 5, i);
		if (s2[0] > 0 && s2[1] > 0 && s2[2] > 0) return r;
		if (s2[0] < 0 && s2[1] < 0 && s2[2] < 0) return r;
		if (s2[0] == 0 && s2[1] * s2[2] > 0) begin r.hit = vtx_in_tri(3, 0); return r; end
		if (s2[1] == 0 && s2[0] * s2[2] > 0) begin r.hit = vtx_in_tri(3, 1); return r; end
		if (s2[2] == 0 && s2[0] * s2[1] > 0) begin r.hit = vtx_in_tri(3, 2); return r; end
		m = -1;
		if (s2[1] * s2[2] >= 0 && s2[0] != 0) m = 0;
		else if (s2[0] * s2[2] >= 0 && s2[1] != 0) begin
			m = 1; tmp = t1[0]; t1[0] = t1[1]; t1[1] = t1[2]; t1[2] = tmp;
		end else if (s2[0] * s2[1] >= 0 && s2[2] != 0) begin
			m = 2; tmp = t1[0]; t1[0] = t1[2]; t1[2] = t1[1]; t1[1] = tmp;
		end
		if (m >= 0 && s2[m] < 0) begin
			tmp = t2[1]; t2[1] = t2[2]; t2[2] = tmp;
			tmp = s1[1]; s1[1] = s1[2]; s1[2] = tmp;
		end
		m = -1;
		if (s1[1] * s1[2] >= 0 && s1[0] != 0) m = 0;
		else if (s1[0] * s1[2] >= 0 && s1[1] != 0) begin
			m = 1; tmp = t2[0]; t2[0] = t2[1]; t2[1] = t2[2]; t2[2] = tmp;
		end else if (s1[0] * s1[1] >= 0 && s1[2] != 0) begin
			m = 2; tmp = t2[0]; t2[0] = t2[2]; t2[2] = t2[1]; t2[1] = tmp;
		end
		if (m >= 0 && s1[m] < 0) begin
			tmp = t1[1]; t1[1] = t1[2]; t1[2] = tmp;
		end
		r.hit = det_sign(t1[0], t1[1], t2[0], t2[1]) <= 0
		     && det_sign(t1[0], t1[2], t2[2], t2[0]) <= 0;
		return r;
	endfunction

	// Updates the vertex copy and returns the verdict, if the beat asks for one.
	function automatic bit apply_beat(vtx_beat_t b, output verdict_t v);
		if (b.slot < 6) begin
			vtx[b.slot][0] = b.x;
			vtx[b.slot][1] = b.y;
			vtx[b.slot][2] = b.z;
		end
		v = '0;
		if (!b.eval) return 1'b0;
		v = triangles_meet();
		return 1'b1;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_beat(vtx_beat_t b);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(DW-3*CB){1'b0}}, b.z, b.y, b.x};
		s_tuser <= {b.eval, b.slot};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic feed(vtx_beat_t b, logic fixed, verdict_t want);
		verdict_t v;
		if (apply_beat(b, v)) begin
			if (fixed && v != want) begin
				$error("directed row disagrees with predictor: %b vs %b", want, v);
				errors++;
			end
			pending_verdicts.push_back(fixed ? want : v);
		end
		send_beat(b);
	endtask

	function automatic coord_t rnd_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 15)) - 8;
			default: return ($urandom_range(0, 1)) ? coord_t'(16'sh7fff) : coord_t'(16'sh8000);
		endcase
	endfunction

	function automatic vtx_beat_t mk(int slot, int x, int y, int z, bit ev);
		vtx_beat_t b;
		b.slot = slot; b.x = x; b.y = y; b.z = z; b.eval = ev;
		return b;
	endfunction

	row_t rows [$];

	initial begin
		vtx_beat_t b;
		verdict_t none;
		int mode;
		none = '0;
		for (int i = 0; i < 6; i++)
			for (int j = 0; j < 3; j++) vtx[i][j] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset all vertices are zero: degenerate coplanar, zero denominators.
		rows.push_back({mk(7, 0, 0, 0, 1), 1'b1, 2'b11});
		// Two triangles crossing in the plain case.
		rows.push_back({mk(0, 0, 0, 0, 0), 1'b0, none});
		rows.push_back({mk(1, 10, 0, 0, 0), 1'b0, none});
		rows.push_back({mk(2, 0, 10, 0, 0), 1'b0, none});
		rows.push_back({mk(3, 2, 2, -5, 0), 1'b0, none});
		rows.push_back({mk(4, 2, 2, 5, 0), 1'b0, none});
		rows.push_back({mk(5, 8, 8, 5, 1), 1'b0, none});
		// Second triangle lifted above: all signs agree.
		rows.push_back({mk(3, 2, 2, 1, 0), 1'b0, none});
		rows.push_back({mk(4, 2, 3, 5, 1), 1'b1, 2'b00});
		// One vertex lying in the plane.
		rows.push_back({mk(3, 1, 1, 0, 1), 1'b0, none});
		// Coplanar triangles, overlapping and apart.
		rows.push_back({mk(4, 5, 1, 0, 0), 1'b0, none});
		rows.push_back({mk(5, 1, 5, 0, 1), 1'b0, none});
		rows.push_back({mk(3, 100, 100, 0, 0), 1'b0, none});
		rows.push_back({mk(4, 105, 100, 0, 0), 1'b0, none});
		rows.push_back({mk(5, 100, 105, 0, 1), 1'b0, none});
		// Coordinate extremes, and an unused slot that stores nothing.
		rows.push_back({mk(0, -32768, -32768, -32768, 0), 1'b0, none});
		rows.push_back({mk(1, 32767, -32768, 32767, 0), 1'b0, none});
		rows.push_back({mk(2, -32768, 32767, 32767, 0), 1'b0, none});
		rows.push_back({mk(6, 32767, 32767, 32767, 0), 1'b0, none});
		rows.push_back({mk(3, 32767, 32767, -32768, 1), 1'b0, none});
		rows.push_back({mk(4, -1, -1, -1, 1), 1'b0, none});
		foreach (rows[i]) feed(rows[i].beat, rows[i].fixed, rows[i].want);

		for (int n = 0; n < N_RANDOM / 6; n++) begin
			mode = $urandom_range(0, 9);
			mode = (mode < 5) ? 1 : ((mode < 9) ? 0 : 2);
			if ($urandom_range(0, 9) == 0) begin
				// Noise: random slots, random evaluates.
				b = mk($urandom_range(0, 7), rnd_coord(mode), rnd_coord(mode),
					rnd_coord(mode), $urandom_range(0, 2) == 0);
				feed(b, 1'b0, none);
			end else begin
				for (int s = 0; s < 6; s++) begin
					// Flat z often, so coplanar and in-plane cases come up.
					b = mk(s, rnd_coord(mode), rnd_coord(mode),
						($urandom_range(0, 2) == 0) ? 0 : rnd_coord(mode), s == 5);
					feed(b, 1'b0, none);
				end
			end
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: random stalls, with one long hold-off early on.
	initial begin
		int g;
		@(posedge arst_n);
		repeat (40) @(posedge clk);
		m_tready <= 1'b0;
		repeat (600) @(posedge clk);
		forever begin
			g = gap_len();
			m_tready <= (g == 0);
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		verdict_t w;
		if (m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result beat with no verdict pending");
				errors++;
			end else begin
				w = pending_verdicts.pop_front();
				if (m_tdata[0] !== w.hit) begin
					$error("intersects: expected %0b, got %0b", w.hit, m_tdata[0]);
					errors++;
				end
				if (m_tuser[0] !== w.copl) begin
					$error("coplanar_case: expected %0b, got %0b", w.copl, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (stim_done && pending_verdicts.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_verdicts.size() == 0)
			$display("triangle_triangle_intersect_3d_top test passed");
		else
			$display("triangle_triangle_intersect_3d_top test failed");
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("triangle_triangle_intersect_3d_top test failed");
			$finish;
		end
	end

endmodule
`default_nettype wire
